[hw/rtl/rcdc_pkg.sv]
package rcdc_pkg;

	localparam int SMP_W     = 8;
	localparam int PIX_W     = 3 * SMP_W;
	localparam int TAP_W     = 16;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 11;
	localparam int NTAPS     = 9;
	localparam int PROD_W    = SMP_W + TAP_W + 1;
	localparam int RSUM_W    = PROD_W + 2;
	localparam int SUM_W     = PROD_W + 4;
	localparam int REM_W     = TAP_W + SMP_W;
	localparam int DIV_STEPS = SMP_W;
	// stages after s1: multiply, row sums, total, setup, then one per quotient bit
	localparam int LANE_LAT  = 4 + DIV_STEPS;
	localparam logic [SMP_W-1:0] CLAMP_MAX = 8'd255;

	localparam logic [2:0] REG_TAPS_TOP    = 3'd0;
	localparam logic [2:0] REG_TAPS_MIDDLE = 3'd1;
	localparam logic [2:0] REG_TAPS_BOTTOM = 3'd2;
	localparam logic [2:0] REG_DIVISOR     = 3'd3;
	localparam logic [2:0] REG_WIDTH       = 3'd4;
	localparam logic [2:0] REG_HEIGHT      = 3'd5;

	typedef logic [SMP_W-1:0] smp_t;
	typedef logic signed [TAP_W-1:0] tap_t;

	typedef struct packed {
		logic             prod;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} meta_t;

endpackage

[hw/rtl/rgb_conv3x3_div_clamp_core.sv]
// 3x3 convolution of an rgb pixel stream in raster order, with a programmable divisor
// and a clamp to 0..255. one pixel is taken per clock while the output side keeps up;
// the whole pipeline holds when a result waits untaken. a pixel's result is carried
// through registered stages: the line store is read at the transfer edge, then one
// multiply stage (nine multiplies per channel lane), two adder stages, a setup stage
// and eight restoring divide stages, the last of which drives the output.
// border pixels give no result; tlast marks the last filtered pixel of the frame.
// taps, divisor and geometry sit on a 64-bit apb port at byte address 8*index.
module rgb_conv3x3_div_clamp_core #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // red_out, green_out, blue_out, centre_row, centre_col
	output logic        m_axis_tlast   // frame_last
);
	import rcdc_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = (AW + 1 > ROW_W) ? AW + 1 : ROW_W;
	localparam int NST = LANE_LAT;

	logic [3*TAP_W-1:0] taps_top_q, taps_mid_q, taps_bot_q;
	logic [TAP_W-1:0]   divisor_q;
	logic [ROW_W-1:0]   width_q, height_q;
	logic [2:0]         reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_top_q <= '0;
			taps_mid_q <= 48'd65536;
			taps_bot_q <= '0;
			divisor_q  <= 16'd1;
			width_q    <= 12'd2048;
			height_q   <= 12'd4095;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_TAPS_TOP:    taps_top_q <= pwdata[47:0];
				REG_TAPS_MIDDLE: taps_mid_q <= pwdata[47:0];
				REG_TAPS_BOTTOM: taps_bot_q <= pwdata[47:0];
				REG_DIVISOR:     divisor_q  <= pwdata[15:0];
				REG_WIDTH:       width_q    <= pwdata[11:0];
				REG_HEIGHT:      height_q   <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TAPS_TOP:    prdata = {16'd0, taps_top_q};
			REG_TAPS_MIDDLE: prdata = {16'd0, taps_mid_q};
			REG_TAPS_BOTTOM: prdata = {16'd0, taps_bot_q};
			REG_DIVISOR:     prdata = {48'd0, divisor_q};
			REG_WIDTH:       prdata = {52'd0, width_q};
			REG_HEIGHT:      prdata = {52'd0, height_q};
			default:         prdata = '0;
		endcase
	end

	// geometry
	logic [WW-1:0]    w_eff, wreg_ext;
	logic [ROW_W-1:0] h_eff;
	logic [AW-1:0]    col_q, c_eff;
	logic [ROW_W-1:0] row_q;
	logic             en, acc;
	meta_t            meta_in;

	assign wreg_ext = WW'(width_q);
	assign w_eff = (wreg_ext < WW'(3)) ? WW'(3)
		: ((wreg_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : wreg_ext);
	assign h_eff = (height_q < 12'd3) ? 12'd3 : height_q;
	assign c_eff = ((AW+1)'(col_q) >= (AW+1)'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : col_q;

	assign en  = !m_axis_tvalid || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		meta_in.prod = (row_q >= 12'd2) && (c_eff >= AW'(2));
		meta_in.row  = row_q - 12'd1;
		meta_in.col  = COL_W'(c_eff - AW'(1));
		meta_in.last = (row_q == h_eff - 12'd1) && (WW'(c_eff) == w_eff - WW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (WW'(col_q) + WW'(1) >= w_eff) begin
				col_q <= '0;
				if ({1'b0, row_q} + 13'd1 >= {1'b0, h_eff})
					row_q <= '0;
				else
					row_q <= row_q + 12'd1;
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// s1: line store read data arrives with the pixel
	logic [PIX_W-1:0] pix_s1, rd_top, rd_mid;
	logic [AW-1:0]    c_s1;
	logic             v_s1;
	meta_t            meta_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= s_axis_tdata;
			c_s1    <= c_eff;
			meta_s1 <= meta_in;
		end
	end

	rcdc_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_store (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (c_eff),
		.wr_en   (en && v_s1),
		.wr_addr (c_s1),
		.wr_top  (rd_mid),
		.wr_mid  (pix_s1),
		.rd_top  (rd_top),
		.rd_mid  (rd_mid)
	);

	// window: left column two pixels back, middle one back, right is the new column
	logic [PIX_W-1:0] win_l_q [3];
	logic [PIX_W-1:0] win_m_q [3];
	logic [PIX_W-1:0] col_r [3];

	assign col_r[0] = rd_top;
	assign col_r[1] = rd_mid;
	assign col_r[2] = pix_s1;

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_l_q[i] <= win_m_q[i];
				win_m_q[i] <= col_r[i];
			end
		end
	end

	tap_t taps [NTAPS];
	smp_t smp [3][NTAPS];
	smp_t lane_res [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			taps[k]   = taps_top_q[TAP_W*k +: TAP_W];
			taps[3+k] = taps_mid_q[TAP_W*k +: TAP_W];
			taps[6+k] = taps_bot_q[TAP_W*k +: TAP_W];
		end
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < 3; i++) begin
				smp[ch][3*i]   = win_l_q[i][SMP_W*ch +: SMP_W];
				smp[ch][3*i+1] = win_m_q[i][SMP_W*ch +: SMP_W];
				smp[ch][3*i+2] = col_r[i][SMP_W*ch +: SMP_W];
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		rcdc_lane u_lane (
			.clk     (clk),
			.en      (en),
			.smp     (smp[ch]),
			.taps    (taps),
			.divisor (divisor_q),
			.result  (lane_res[ch])
		);
	end

	// result tags travel beside the lanes; the last stage is the output register
	logic  vld_q  [NST];
	meta_t meta_q [NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NST; s++)
				vld_q[s] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= v_s1 && meta_s1.prod;
			for (int s = 1; s < NST; s++)
				vld_q[s] <= vld_q[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q[0] <= meta_s1;
			for (int s = 1; s < NST; s++)
				meta_q[s] <= meta_q[s-1];
		end
	end

	assign m_axis_tvalid = vld_q[NST-1];
	assign m_axis_tlast  = meta_q[NST-1].last;
	assign m_axis_tdata  = {1'b0, meta_q[NST-1].col, meta_q[NST-1].row,
		lane_res[2], lane_res[1], lane_res[0]};

	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted pixel did not reach s1");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(vld_q[0]))
		else $error("pipeline moved while stalled");

	a_row_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> meta_q[NST-1].row != '0)
		else $error("result from a border row");

	a_border: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && row_q < 12'd2) |=> !(v_s1 && meta_s1.prod))
		else $error("border pixel marked as producing");

endmodule

[hw/rtl/rcdc_line_store.sv]
module rcdc_line_store #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  logic [rcdc_pkg::PIX_W-1:0]   wr_top,
	input  logic [rcdc_pkg::PIX_W-1:0]   wr_mid,
	output logic [rcdc_pkg::PIX_W-1:0]   rd_top,
	output logic [rcdc_pkg::PIX_W-1:0]   rd_mid
);
	import rcdc_pkg::*;

	logic [PIX_W-1:0] mem_top [MAX_WIDTH];
	logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_top[wr_addr] <= wr_top;
			mem_mid[wr_addr] <= wr_mid;
		end
		if (rd_en) begin
			rd_top <= mem_top[rd_addr];
			rd_mid <= mem_mid[rd_addr];
		end
	end

endmodule

[hw/rtl/rcdc_lane.sv]
module rcdc_lane (
	input  logic                 clk,
	input  logic                 en,
	input  rcdc_pkg::smp_t       smp [rcdc_pkg::NTAPS],
	input  rcdc_pkg::tap_t       taps [rcdc_pkg::NTAPS],
	input  logic [rcdc_pkg::TAP_W-1:0] divisor,
	output rcdc_pkg::smp_t       result
);
	import rcdc_pkg::*;

	logic signed [PROD_W-1:0] prod_s2 [NTAPS];
	logic signed [RSUM_W-1:0] rsum_s3 [3];
	logic signed [SUM_W-1:0]  sum_s4;
	logic [TAP_W-1:0]         d_eff;
	logic [REM_W-1:0]         rem_q [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]     quo_q [DIV_STEPS+1];
	logic                     sat_q [DIV_STEPS+1];

	assign d_eff = (divisor == '0) ? TAP_W'(1) : divisor;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < NTAPS; j++)
				prod_s2[j] <= $signed({1'b0, smp[j]}) * PROD_W'(taps[j]);
			for (int i = 0; i < 3; i++)
				rsum_s3[i] <= RSUM_W'(prod_s2[3*i]) + RSUM_W'(prod_s2[3*i+1])
					+ RSUM_W'(prod_s2[3*i+2]);
			sum_s4 <= SUM_W'(rsum_s3[0]) + SUM_W'(rsum_s3[1]) + SUM_W'(rsum_s3[2]);
			// negative sums clamp to zero, quotients past 255 saturate
			sat_q[0] <= !sum_s4[SUM_W-1] &&
				(sum_s4 >= $signed({{(SUM_W-REM_W){1'b0}}, d_eff, {SMP_W{1'b0}}}));
			rem_q[0] <= sum_s4[SUM_W-1] ? '0 : sum_s4[REM_W-1:0];
			quo_q[0] <= '0;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - 1 - k;
		logic [REM_W-1:0] dsh;
		assign dsh = REM_W'({d_eff, {B{1'b0}}});
		always_ff @(posedge clk) begin
			if (en) begin
				sat_q[k+1] <= sat_q[k];
				if (rem_q[k] >= dsh) begin
					rem_q[k+1] <= rem_q[k] - dsh;
					quo_q[k+1] <= quo_q[k] | (DIV_STEPS'(1) << B);
				end else begin
					rem_q[k+1] <= rem_q[k];
					quo_q[k+1] <= quo_q[k];
				end
			end
		end
	end

	assign result = sat_q[DIV_STEPS] ? CLAMP_MAX : quo_q[DIV_STEPS];

endmodule

[tb/testbench.sv]
module testbench;
	import rcdc_pkg::*;

	localparam int LINE_MAX = 2048;

	typedef struct {
		smp_t             red;
		smp_t             green;
		smp_t             blue;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} filtered_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;  // red_in, green_in, blue_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;  // red_out, green_out, blue_out, centre_row, centre_col
	logic        m_axis_tlast;  // frame_last

	// predictor state
	logic [47:0]      taps [3];
	logic [15:0]      div_cfg;
	logic [11:0]      width_cfg;
	logic [11:0]      height_cfg;
	logic [PIX_W-1:0] line_mem [2*LINE_MAX];
	logic [PIX_W-1:0] window [6];
	int               col_cnt;
	int               row_cnt;

	filtered_pixel_t filtered_q[$];
	int errors;
	int send_idle;
	int recv_stall;
	int hold_left;

	rgb_conv3x3_div_clamp_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int eff_width();
		int w;
		w = (width_cfg < 3) ? 3 : width_cfg;
		if (w > LINE_MAX)
			w = LINE_MAX;
		return w;
	endfunction

	function automatic int eff_height();
		return (height_cfg < 3) ? 3 : height_cfg;
	endfunction

	// window centre filter for one accepted pixel
	function automatic void filter_pixel(input logic [PIX_W-1:0] pix);
		int w, h, c, r, sum, t, s, res;
		logic [PIX_W-1:0] col [3];
		logic [PIX_W-1:0] p [3];
		smp_t chan [3];
		filtered_pixel_t e;
		w = eff_width();
		h = eff_height();
		c = col_cnt;
		r = row_cnt;
		if (c >= LINE_MAX)
			c = LINE_MAX - 1;
		col[0] = line_mem[c];
		col[1] = line_mem[LINE_MAX + c];
		col[2] = pix;
		if (r >= 2 && c >= 2) begin
			for (int ch = 0; ch < 3; ch++) begin
				sum = 0;
				for (int i = 0; i < 3; i++) begin
					p[0] = window[i];
					p[1] = window[3+i];
					p[2] = col[i];
					for (int k = 0; k < 3; k++) begin
						t = $signed(taps[i][16*k +: 16]);
						s = int'(p[k][8*ch +: 8]);
						sum += s * t;
					end
				end
				if (div_cfg != 16'd0 && div_cfg != 16'd1)
					sum = sum / int'(div_cfg);
				res = (sum < 0) ? 0 : (sum > 255) ? 255 : sum;
				chan[ch] = res[7:0];
			end
			e.red = chan[0];
			e.green = chan[1];
			e.blue = chan[2];
			e.row = ROW_W'(r - 1);
			e.col = COL_W'(c - 1);
			e.last = (r == h - 1 && c == w - 1);
			filtered_q.push_back(e);
		end
		line_mem[c] = col[1];
		line_mem[LINE_MAX + c] = pix;
		for (int i = 0; i < 3; i++)
			window[i] = window[3+i];
		window[3] = col[0];
		window[4] = col[1];
		window[5] = col[2];
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & 12'hfff);
		end else begin
			col_cnt = (col_cnt + 1) & 11'h7ff;
		end
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_result();
		filtered_pixel_t e;
		if (filtered_q.size() == 0) begin
			report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
			return;
		end
		e = filtered_q.pop_front();
		if (m_axis_tdata[7:0] !== e.red)
			report_mismatch($sformatf("red %0d, want %0d", m_axis_tdata[7:0], e.red));
		if (m_axis_tdata[15:8] !== e.green)
			report_mismatch($sformatf("green %0d, want %0d", m_axis_tdata[15:8], e.green));
		if (m_axis_tdata[23:16] !== e.blue)
			report_mismatch($sformatf("blue %0d, want %0d", m_axis_tdata[23:16], e.blue));
		if (m_axis_tdata[35:24] !== e.row)
			report_mismatch($sformatf("row %0d, want %0d", m_axis_tdata[35:24], e.row));
		if (m_axis_tdata[46:36] !== e.col)
			report_mismatch($sformatf("col %0d, want %0d", m_axis_tdata[46:36], e.col));
		if (m_axis_tdata[47] !== 1'b0)
			report_mismatch("pad bit set");
		if (m_axis_tlast !== e.last)
			report_mismatch($sformatf("last %b, want %b", m_axis_tlast, e.last));
	endtask

	// result side: checks each transfer and stalls at random or for a long hold
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result();
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left--;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		while ($urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do
			@(posedge clk);
		while (!s_axis_tready);
		filter_pixel(pix);
	endtask

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] v;
		v = PIX_W'($urandom);
		for (int ch = 0; ch < 3; ch++)
			case ($urandom_range(0, 7))
				0: v[8*ch +: 8] = 8'h00;
				1: v[8*ch +: 8] = CLAMP_MAX;
				default: ;
			endcase
		return v;
	endfunction

	task automatic send_frames(input int count);
		repeat (count * eff_width() * eff_height())
			send_pixel(random_pixel());
	endtask

	// waits out the pipeline so that registers change only while idle
	task automatic drain();
		int guard;
		s_axis_tvalid <= 1'b0;
		guard = 0;
		while (filtered_q.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LANE_LAT + 20)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_TAPS_TOP:    taps[0] = val[47:0];
			REG_TAPS_MIDDLE: taps[1] = val[47:0];
			REG_TAPS_BOTTOM: taps[2] = val[47:0];
			REG_DIVISOR:     div_cfg = val[15:0];
			REG_WIDTH:       width_cfg = val[11:0];
			REG_HEIGHT:      height_cfg = val[11:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [11:0] w, input logic [11:0] h);
		apb_write(REG_WIDTH, 64'(w));
		apb_write(REG_HEIGHT, 64'(h));
	endtask

	task automatic set_all_taps(input logic [15:0] t, input logic [15:0] d);
		apb_write(REG_TAPS_TOP, 64'({t, t, t}));
		apb_write(REG_TAPS_MIDDLE, 64'({t, t, t}));
		apb_write(REG_TAPS_BOTTOM, 64'({t, t, t}));
		apb_write(REG_DIVISOR, 64'(d));
	endtask

	// out-of-range geometry, zero divisor, extreme taps and samples
	task automatic test_directed();
		set_geometry(12'd1, 12'd0);
		apb_write(REG_DIVISOR, 64'd0);
		for (int i = 0; i < 9; i++)
			send_pixel((i % 2) ? 24'hffffff : 24'h000000);
		drain();
		set_all_taps(16'h7fff, 16'hffff);
		repeat (9)
			send_pixel(24'hffffff);
		drain();
		set_all_taps(16'h8000, 16'd1);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 4) ? 24'h000000 : 24'hff00ff);
		drain();
	endtask

	// a longer row with a box average over the window
	task automatic test_widest_row();
		set_all_taps(16'h0001, 16'd9);
		set_geometry(12'd30, 12'd3);
		send_frames(1);
		drain();
	endtask

	// tallest height, then the height shrinks at a row start and the row count wraps
	task automatic test_tall_frame();
		set_geometry(12'd3, 12'd4095);
		repeat (3 * 40)
			send_pixel(random_pixel());
		drain();
		apb_write(REG_HEIGHT, 64'd3);
		repeat (3 + 9)
			send_pixel(random_pixel());
		drain();
	endtask

	function automatic logic [15:0] random_tap();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'hffff;
			3: return 16'h0000;
			4, 5, 6: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_setup();
		logic [15:0] d;
		logic [11:0] w, h;
		for (int i = 0; i < 3; i++)
			apb_write(REG_TAPS_TOP + 3'(i), 64'({random_tap(), random_tap(), random_tap()}));
		case ($urandom_range(0, 7))
			0: d = 16'd0;
			1: d = 16'hffff;
			2: d = 16'($urandom);
			default: d = 16'($urandom_range(1, 16));
		endcase
		apb_write(REG_DIVISOR, 64'(d));
		w = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 12));
		h = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 2)) : 12'($urandom_range(3, 8));
		set_geometry(w, h);
	endtask

	task automatic test_random_frames();
		int sent;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 58; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 58; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			sent = 0;
			while (sent < 120) begin
				random_setup();
				send_frames($urandom_range(1, 2));
				sent += eff_width() * eff_height();
				drain();
			end
		end
		send_idle = 0;
		recv_stall = 0;
	endtask

	// long output hold while pixels keep coming, so the input side must stall
	task automatic test_output_hold();
		set_all_taps(16'h0001, 16'd5);
		set_geometry(12'd8, 12'd8);
		hold_left = 300;
		send_frames(1);
		drain();
	endtask

	initial begin
		errors = 0;
		send_idle = 0;
		recv_stall = 0;
		hold_left = 0;
		taps[0] = '0;
		taps[1] = 48'd65536;
		taps[2] = '0;
		div_cfg = 16'd1;
		width_cfg = 12'd2048;
		height_cfg = 12'd4095;
		col_cnt = 0;
		row_cnt = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_widest_row();
		test_tall_frame();
		test_random_frames();
		test_output_hold();
		drain();
		if (errors == 0 && filtered_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#40000000;
		$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rcdc_pkg.sv
hw/rtl/rcdc_line_store.sv
hw/rtl/rcdc_lane.sv
hw/rtl/rgb_conv3x3_div_clamp_core.sv
tb/testbench.sv
